// ===== design/vpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes of the variable partition allocator.
// Depends on nothing; every other file of the block imports it.
package vpa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int SIZE_BITS    = 20;
    localparam int ID_BITS      = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(MAX_SEGMENTS - 1);
    localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(MAX_SEGMENTS);
    localparam logic [SIZE_BITS-1:0] MEM_RESET = {SIZE_BITS{1'b1}};
    localparam logic [ID_BITS-1:0]   ID_FIRST  = ID_BITS'(1);
    localparam logic [ID_BITS-1:0]   ID_SECOND = ID_BITS'(2);

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_MEMORY_SIZE = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOFIT,
        ST_NOTFOUND,
        ST_FULL
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_PACK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_SHIFT,
        CM_SWAP,
        CM_INIT
    } cell_mode_t;

    typedef struct packed {
        logic                 valid;
        logic                 busy;
        logic [SIZE_BITS-1:0] size;
        logic [ID_BITS-1:0]   ident;
    } seg_t;

    typedef struct packed {
        cell_mode_t           mode;
        logic                 phase;
        logic [SIZE_BITS-1:0] init_size;
    } cell_cmd_t;

endpackage

// ===== design/vpa_cell.sv =====
`timescale 1ns / 1ps
// One segment slot of the allocator's cell chain.
// Depends on vpa_pkg for the segment and command types.
module vpa_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  vpa_pkg::cell_cmd_t cmd,
    input  logic              is_first,
    input  logic              parity,
    input  vpa_pkg::seg_t     left,
    input  vpa_pkg::seg_t     right,
    output vpa_pkg::seg_t     entry
);
    import vpa_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic                 busy_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [ID_BITS-1:0]   ident_reg;
    seg_t                 cur;
    seg_t                 seg_next;

    assign cur   = '{valid: valid_reg, busy: busy_reg, size: size_reg, ident: ident_reg};
    assign entry = cur;

    always_comb
    begin
        seg_next = cur;
        unique case (cmd.mode)
            CM_HOLD:
            begin
                seg_next = cur;
            end
            CM_SHIFT:
            begin
                seg_next = right;
            end
            CM_SWAP:
            begin
                if (parity == cmd.phase)
                begin
                    if (!cur.valid && right.valid)
                    begin
                        seg_next = right;
                    end
                end
                else
                begin
                    if (!left.valid && cur.valid)
                    begin
                        seg_next = left;
                    end
                end
            end
            CM_INIT:
            begin
                seg_next = '{valid: is_first, busy: 1'b0, size: cmd.init_size,
                             ident: ID_FIRST};
            end
            default:
            begin
                seg_next = cur;
            end
        endcase
        valid_next = seg_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_reg  <= seg_next.busy;
        size_reg  <= seg_next.size;
        ident_reg <= seg_next.ident;
    end

endmodule

// ===== design/vpa_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the allocator: handshakes, fit search, split, merge and packing passes.
// Depends on vpa_pkg; drives the shared command and the tail input of the cell chain.
module vpa_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [vpa_pkg::SIZE_BITS-1:0] request_size,
    input  logic [vpa_pkg::ID_BITS-1:0]   target_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [vpa_pkg::ID_BITS-1:0]   granted_id,
    output logic [vpa_pkg::SIZE_BITS-1:0] free_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [vpa_pkg::SIZE_BITS-1:0] cfg_data,
    input  vpa_pkg::seg_t                 head,
    input  vpa_pkg::seg_t                 second,
    output vpa_pkg::seg_t                 tail,
    output vpa_pkg::cell_cmd_t            cmd
);
    import vpa_pkg::*;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 func_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [ID_BITS-1:0]   tid_reg;
    logic [1:0]           policy_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [SIZE_BITS-1:0] sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [ID_BITS-1:0]   next_id_reg;
    seg_t                 delay_reg;
    logic                 delay_on_reg;
    logic                 carry_on_reg;
    logic [SIZE_BITS-1:0] carry_size_reg;
    logic [ID_BITS-1:0]   carry_id_reg;
    status_t              res_status_reg;
    logic [ID_BITS-1:0]   res_gid_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [ID_BITS-1:0]   out_gid_reg;
    logic [SIZE_BITS-1:0] out_free_reg;

    logic                 last;
    logic                 in_fire;
    logic                 cfg_fire;
    logic                 cand;
    logic                 take;
    logic                 hit;
    logic                 at_pick;
    logic                 exact;
    logic                 eff_busy_h;
    logic                 eff_busy_n;
    logic                 merge;
    logic [IDX_W-1:0]     nxt_idx;
    logic [ID_BITS-1:0]   id_inc;
    logic [ID_BITS-1:0]   id_adv;
    logic                 out_free_slot;

    assign last          = (cnt_reg == LAST_IDX);
    assign in_fire       = in_valid && in_ready;
    assign cfg_ready     = (state_reg == S_IDLE) || (state_reg == S_INIT);
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_id    = out_gid_reg;
    assign free_total    = out_free_reg;
    assign out_free_slot = !out_valid_reg || out_ready;
    assign exact         = (pick_size_reg == req_reg);
    assign at_pick       = (cnt_reg == pick_reg);
    assign nxt_idx       = cnt_reg + IDX_W'(1);
    assign id_inc        = next_id_reg + ID_BITS'(1);
    assign id_adv        = (id_inc == '0) ? ID_FIRST : id_inc;

    assign cand = head.valid && !head.busy && (head.size >= req_reg);
    assign take = cand && (!found_reg
                  || (policy_reg == POL_BEST && head.size < pick_size_reg)
                  || (policy_reg == POL_WORST && head.size > pick_size_reg));
    assign hit  = head.valid && (head.ident == tid_reg) && (tid_reg != '0) && !found_reg;

    assign eff_busy_h = head.busy && !at_pick;
    assign eff_busy_n = second.busy && (nxt_idx != pick_reg);
    assign merge      = !last && head.valid && !eff_busy_h && second.valid && !eff_busy_n;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (req_reg != '0 && found_reg && (exact || count_reg != FULL_CNT))
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (found_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (last)
                begin
                    state_next = (func_reg == FUNC_FREE) ? S_PACK : S_DONE;
                end
            end
            S_PACK:
            begin
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free_slot)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        tail          = '0;
        cmd.mode      = CM_HOLD;
        cmd.phase     = cnt_reg[0];
        cmd.init_size = (cfg_fire && cfg_index == CFG_MEMORY_SIZE) ? cfg_data : MEM_RESET;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.mode = CM_INIT;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (cfg_fire && cfg_index == CFG_MEMORY_SIZE)
                begin
                    cmd.mode = CM_INIT;
                end
            end
            S_SCAN:
            begin
                cmd.mode = CM_SHIFT;
                tail     = head;
            end
            S_WRITE:
            begin
                cmd.mode = CM_SHIFT;
                if (func_reg == FUNC_ALLOC)
                begin
                    if (delay_on_reg)
                    begin
                        tail = delay_reg;
                    end
                    else if (at_pick)
                    begin
                        tail = '{valid: 1'b1, busy: 1'b1, size: req_reg, ident: head.ident};
                    end
                    else
                    begin
                        tail = head;
                    end
                end
                else if (!merge)
                begin
                    tail.valid = head.valid;
                    tail.busy  = eff_busy_h;
                    tail.size  = carry_on_reg ? carry_size_reg + head.size : head.size;
                    tail.ident = carry_on_reg ? carry_id_reg : head.ident;
                end
            end
            S_PACK:
            begin
                cmd.mode = CM_SWAP;
            end
            S_DECIDE, S_DONE:
            begin
                cmd.mode = CM_HOLD;
            end
            default:
            begin
                cmd.mode = CM_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            policy_reg    <= POL_WORST;
            count_reg     <= CNT_W'(1);
            next_id_reg   <= ID_SECOND;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            delay_on_reg  <= 1'b0;
            carry_on_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free_slot)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_fire && cfg_index == CFG_FIT_POLICY)
            begin
                policy_reg <= cfg_data[1:0];
            end
            if (cmd.mode == CM_INIT)
            begin
                count_reg   <= CNT_W'(1);
                next_id_reg <= ID_SECOND;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg      <= '0;
                    found_reg    <= 1'b0;
                    delay_on_reg <= 1'b0;
                    carry_on_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    cnt_reg <= last ? '0 : nxt_idx;
                    if ((func_reg == FUNC_ALLOC && take) || (func_reg == FUNC_FREE && hit))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_WRITE:
                begin
                    cnt_reg <= last ? '0 : nxt_idx;
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (delay_on_reg)
                        begin
                            delay_reg <= head;
                        end
                        else if (at_pick && !exact)
                        begin
                            delay_reg    <= '{valid: 1'b1, busy: 1'b0,
                                              size: head.size - req_reg,
                                              ident: next_id_reg};
                            delay_on_reg <= 1'b1;
                            next_id_reg  <= id_adv;
                            count_reg    <= count_reg + CNT_W'(1);
                        end
                    end
                    else if (merge)
                    begin
                        carry_on_reg <= 1'b1;
                        count_reg    <= count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        carry_on_reg <= 1'b0;
                    end
                end
                S_PACK:
                begin
                    cnt_reg <= last ? '0 : nxt_idx;
                end
                S_DONE:
                begin
                    cnt_reg <= '0;
                end
                S_INIT, S_DECIDE:
                begin
                    cnt_reg <= '0;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg    <= func;
            req_reg     <= request_size;
            tid_reg     <= target_id;
            sum_reg     <= '0;
            res_gid_reg <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (head.valid && !head.busy)
            begin
                sum_reg <= sum_reg + head.size;
            end
            if ((func_reg == FUNC_ALLOC && take) || (func_reg == FUNC_FREE && hit))
            begin
                pick_reg      <= cnt_reg;
                pick_size_reg <= head.size;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            if (state_next == S_WRITE)
            begin
                sum_reg        <= '0;
                res_status_reg <= ST_OK;
            end
            else if (func_reg == FUNC_FREE)
            begin
                res_status_reg <= ST_NOTFOUND;
            end
            else if (req_reg == '0 || !found_reg)
            begin
                res_status_reg <= ST_NOFIT;
            end
            else
            begin
                res_status_reg <= ST_FULL;
            end
        end
        if (state_reg == S_WRITE)
        begin
            if (tail.valid && !tail.busy)
            begin
                sum_reg <= sum_reg + tail.size;
            end
            if (func_reg == FUNC_ALLOC && at_pick && !delay_on_reg)
            begin
                res_gid_reg <= head.ident;
            end
            if (func_reg == FUNC_FREE && merge)
            begin
                carry_size_reg <= carry_on_reg ? carry_size_reg + head.size : head.size;
                carry_id_reg   <= carry_on_reg ? carry_id_reg : head.ident;
            end
        end
        if (state_reg == S_DONE && out_free_slot)
        begin
            out_status_reg <= res_status_reg;
            out_gid_reg    <= res_gid_reg;
            out_free_reg   <= sum_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= FULL_CNT))
        else $error("Segment count left its range.");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> head.valid)
        else $error("Table is empty while idle.");

    a_ident_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("Fresh identifier is zero.");

    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && func_reg == FUNC_ALLOC && found_reg)
        |-> (pick_size_reg >= req_reg))
        else $error("Chosen segment is smaller than the request.");

endmodule

// ===== design/variable_partition_allocator.sv =====
`timescale 1ns / 1ps
// Variable partition allocator: top level joining the sequencer and the cell chain.
// Depends on vpa_pkg, vpa_cell and vpa_seq.
//
// Requests arrive on the in channel (func, request_size, target_id) and each one
// yields exactly one transaction on the out channel (status, granted_id, free_total).
// The segment table lives in a chain of MAX_SEGMENTS cells that rotates one place a
// cycle during the search and rewrite passes; the sequencer watches the head cell and
// rewrites the tail. A successful allocation makes a search pass and a rewrite pass
// with any split; a failed request of either kind makes only the search pass. A
// successful free makes a search pass, a rewrite with merging, and an odd-even packing
// pass that moves the holes left by merging to the end.
// One request is worked on at a time; the next is accepted in the cycle after the result
// is registered.
// The configuration channel is ready whenever no request is in progress; a write of
// memory_size rebuilds the table as one free segment, and after reset the table is
// built in the initial state.
// A finished result waits in the output register while the receiver stalls; the next
// request is taken as soon as the result is registered, and its own result waits until
// the earlier transaction has completed.
module variable_partition_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [vpa_pkg::SIZE_BITS-1:0] request_size,
    input  logic [vpa_pkg::ID_BITS-1:0]   target_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [vpa_pkg::ID_BITS-1:0]   granted_id,
    output logic [vpa_pkg::SIZE_BITS-1:0] free_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [vpa_pkg::SIZE_BITS-1:0] cfg_data
);
    import vpa_pkg::*;

    localparam seg_t EDGE_SEG = '{valid: 1'b1, busy: 1'b1, size: '0, ident: '0};

    seg_t      entries [MAX_SEGMENTS];
    seg_t      tail;
    cell_cmd_t cmd;

    vpa_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .request_size (request_size),
        .target_id    (target_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .granted_id   (granted_id),
        .free_total   (free_total),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head         (entries[0]),
        .second       (entries[1]),
        .tail         (tail),
        .cmd          (cmd)
    );

    for (genvar k = 0; k < MAX_SEGMENTS; k++)
    begin : g_cell
        seg_t left_in;
        seg_t right_in;

        if (k == 0)
        begin : g_first
            assign left_in = EDGE_SEG;
        end
        else
        begin : g_mid_left
            assign left_in = entries[k-1];
        end

        if (k == MAX_SEGMENTS - 1)
        begin : g_last
            assign right_in = tail;
        end
        else
        begin : g_mid_right
            assign right_in = entries[k+1];
        end

        vpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .is_first (k == 0),
            .parity   (1'(k % 2)),
            .left     (left_in),
            .right    (right_in),
            .entry    (entries[k])
        );
    end

endmodule
